// ----- rtl/disk_request_queue_lba28_issuer_macros.svh -----
// Assertion macros shared by the disk request queue design.
`ifndef DISK_REQUEST_QUEUE_LBA28_ISSUER_MACROS_SVH
`define DISK_REQUEST_QUEUE_LBA28_ISSUER_MACROS_SVH
`ifndef ASSERT_OFF
`define DRQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DRQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DRQ_ASSERT(label, prop, msg)
`define DRQ_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- rtl/drq_pkg.sv -----
// Types and constants of the disk request queue.
package drq_pkg;

  typedef struct packed {
    logic        is_read;
    logic [26:0] block_number;
    logic [7:0]  buffer_tag;
  } req_entry_t;

  localparam logic [1:0] OP_ISSUE  = 2'd0;
  localparam logic [1:0] OP_RETIRE = 2'd1;
  localparam logic [1:0] OP_REJECT = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    req_entry_t cur;
    logic       nxt_valid;
    req_entry_t nxt;
  } cmd_t;

  typedef struct packed {
    logic       drive_select;
    logic [7:0] read_opcode;
    logic [7:0] write_opcode;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic empty;
    logic full;
  } front_stat_t;

  localparam logic REQ_SUBMIT    = 1'b0;
  localparam logic REQ_INTERRUPT = 1'b1;

  localparam logic [1:0] REG_DRIVE_SELECT = 2'd0;
  localparam logic [1:0] REG_READ_OPCODE  = 2'd1;
  localparam logic [1:0] REG_WRITE_OPCODE = 2'd2;

  localparam logic [7:0] READ_OPCODE_RESET  = 8'h20;
  localparam logic [7:0] WRITE_OPCODE_RESET = 8'h30;

  localparam logic [2:0] KIND_PORT   = 3'd0;
  localparam logic [2:0] KIND_PUSH   = 3'd1;
  localparam logic [2:0] KIND_PULL   = 3'd2;
  localparam logic [2:0] KIND_DONE   = 3'd3;
  localparam logic [2:0] KIND_REJECT = 3'd4;

  localparam logic [2:0] PW_CTRL  = 3'd0;
  localparam logic [2:0] PW_COUNT = 3'd1;
  localparam logic [2:0] PW_LBA0  = 3'd2;
  localparam logic [2:0] PW_LBA1  = 3'd3;
  localparam logic [2:0] PW_LBA2  = 3'd4;
  localparam logic [2:0] PW_DEV   = 3'd5;
  localparam logic [2:0] PW_CMD   = 3'd6;

  localparam logic [9:0] PORT_CTRL    = 10'h3F6;
  localparam logic [9:0] PORT_SECCNT  = 10'h1F2;
  localparam logic [9:0] PORT_LBA0    = 10'h1F3;
  localparam logic [9:0] PORT_LBA1    = 10'h1F4;
  localparam logic [9:0] PORT_LBA2    = 10'h1F5;
  localparam logic [9:0] PORT_DEVSEL  = 10'h1F6;
  localparam logic [9:0] PORT_COMMAND = 10'h1F7;

  localparam logic [7:0] DEV_LBA_BASE = 8'hE0;
  localparam logic [7:0] LBA_TOP_MASK = 8'h0F;

endpackage

// ----- rtl/drq_front.sv -----
// Front end: accepts items, keeps the request queue and the drive state, and issues commands.
module drq_front import drq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic        is_read,
  input  logic [26:0] block_number,
  input  logic [7:0]  buffer_tag,
  output logic        cmd_push,
  output cmd_t        cmd_data,
  input  logic        cmd_room,
  output front_stat_t stat
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic ST_ACCEPT = 1'b0;
  localparam logic ST_FETCH  = 1'b1;

  req_entry_t      mem [QUEUE_DEPTH];
  req_entry_t      rd_data;
  req_entry_t      cur;
  req_entry_t      in_entry;
  logic            state;
  logic [AW-1:0]   oldest;
  logic [AW-1:0]   newest;
  logic [AW-1:0]   oldest_inc;
  logic [AW-1:0]   newest_inc;
  logic [CW-1:0]   count;
  logic            busy;
  logic            accept;
  logic            full;
  logic            wr_en;
  logic            rd_en;

  assign in_entry   = '{is_read: is_read, block_number: block_number, buffer_tag: buffer_tag};
  assign full       = (count == CW'(QUEUE_DEPTH));
  assign in_ready   = (state == ST_ACCEPT) && cmd_room;
  assign accept     = in_valid && in_ready;
  assign oldest_inc = (oldest == AW'(QUEUE_DEPTH - 1)) ? '0 : oldest + AW'(1);
  assign newest_inc = (newest == AW'(QUEUE_DEPTH - 1)) ? '0 : newest + AW'(1);
  assign wr_en      = accept && (req_type == REQ_SUBMIT) && !full;
  assign rd_en      = accept && (req_type == REQ_INTERRUPT) && busy && (count != '0);

  assign stat = '{busy: busy, empty: (count == '0), full: full};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[newest] <= in_entry;
    end
    if (rd_en) begin
      rd_data <= mem[oldest_inc];
    end
  end

  always_comb begin
    cmd_push = 1'b0;
    cmd_data = '{op: OP_ISSUE, cur: in_entry, nxt_valid: 1'b0, nxt: rd_data};
    if (state == ST_FETCH) begin
      cmd_push = 1'b1;
      cmd_data = '{op: OP_RETIRE, cur: cur, nxt_valid: (count != '0), nxt: rd_data};
    end else if (accept && (req_type == REQ_SUBMIT)) begin
      if (full) begin
        cmd_push    = 1'b1;
        cmd_data.op = OP_REJECT;
      end else if (!busy) begin
        cmd_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_ACCEPT;
      oldest <= '0;
      newest <= '0;
      count  <= '0;
      busy   <= 1'b0;
    end else if (state == ST_FETCH) begin
      state <= ST_ACCEPT;
      busy  <= (count != '0);
      if (count != '0) begin
        cur <= rd_data;
      end
    end else if (accept) begin
      if (req_type == REQ_SUBMIT) begin
        if (!full) begin
          newest <= newest_inc;
          count  <= count + CW'(1);
          if (!busy) begin
            busy <= 1'b1;
            cur  <= in_entry;
          end
        end
      end else if (rd_en) begin
        state  <= ST_FETCH;
        oldest <= oldest_inc;
        count  <= count - CW'(1);
        busy   <= 1'b0;
      end else begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/drq_cmd_fifo.sv -----
// Two-entry command queue between the front end and the result sequencer.
module drq_cmd_fifo import drq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic room,
  input  logic pop,
  output logic avail,
  output cmd_t pop_data
);

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;

  assign room     = (cnt != 2'd2);
  assign avail    = (cnt != 2'd0);
  assign pop_data = slot[rd_ptr];
  assign do_push  = push && room;
  assign do_pop   = pop && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/drq_back.sv -----
// Result sequencer: turns commands into port writes, data requests, completion and reject results.
module drq_back import drq_pkg::*; #(
  parameter int SECTORS_PER_BLOCK = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_avail,
  input  cmd_t       cmd_data,
  output logic       cmd_pop,
  input  cfg_t       cfg,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] result_kind,
  output logic [9:0] port_address,
  output logic [7:0] port_value,
  output logic [7:0] result_tag,
  output logic       last_result
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REJECT = 3'd1;
  localparam logic [2:0] ST_PULL   = 3'd2;
  localparam logic [2:0] ST_DONE   = 3'd3;
  localparam logic [2:0] ST_PORT   = 3'd4;
  localparam logic [2:0] ST_PUSH   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] port_idx;
  logic [2:0] port_idx_next;
  req_entry_t cur;
  req_entry_t nxt;
  logic       nxt_valid;
  req_entry_t ent;
  req_entry_t ent_next;
  logic       adv;
  logic       emit;
  logic [27:0] lba;
  logic [9:0] pw_addr;
  logic [7:0] pw_val;
  logic [2:0] e_kind;
  logic [9:0] e_addr;
  logic [7:0] e_val;
  logic [7:0] e_tag;
  logic       e_last;

  assign adv     = !out_valid || out_ready;
  assign emit    = (state != ST_IDLE) && adv;
  assign cmd_pop = (state == ST_IDLE) && cmd_avail;
  assign lba     = 28'(32'(ent.block_number) * 32'(SECTORS_PER_BLOCK));

  always_comb begin
    case (port_idx)
      PW_CTRL: begin
        pw_addr = PORT_CTRL;
        pw_val  = 8'h00;
      end
      PW_COUNT: begin
        pw_addr = PORT_SECCNT;
        pw_val  = 8'(SECTORS_PER_BLOCK);
      end
      PW_LBA0: begin
        pw_addr = PORT_LBA0;
        pw_val  = lba[7:0];
      end
      PW_LBA1: begin
        pw_addr = PORT_LBA1;
        pw_val  = lba[15:8];
      end
      PW_LBA2: begin
        pw_addr = PORT_LBA2;
        pw_val  = lba[23:16];
      end
      PW_DEV: begin
        pw_addr = PORT_DEVSEL;
        pw_val  = DEV_LBA_BASE | {3'b000, cfg.drive_select, 4'h0}
                  | ({4'h0, lba[27:24]} & LBA_TOP_MASK);
      end
      PW_CMD: begin
        pw_addr = PORT_COMMAND;
        pw_val  = ent.is_read ? cfg.read_opcode : cfg.write_opcode;
      end
      default: begin
        pw_addr = '0;
        pw_val  = '0;
      end
    endcase
  end

  always_comb begin
    e_kind        = KIND_PORT;
    e_addr        = '0;
    e_val         = '0;
    e_tag         = '0;
    e_last        = 1'b0;
    state_next    = state;
    port_idx_next = port_idx;
    ent_next      = ent;
    case (state)
      ST_IDLE: begin
        if (cmd_avail) begin
          ent_next      = cmd_data.cur;
          port_idx_next = PW_CTRL;
          case (cmd_data.op)
            OP_ISSUE:  state_next = ST_PORT;
            OP_RETIRE: state_next = cmd_data.cur.is_read ? ST_PULL : ST_DONE;
            OP_REJECT: state_next = ST_REJECT;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_REJECT: begin
        e_kind = KIND_REJECT;
        e_tag  = cur.buffer_tag;
        e_last = 1'b1;
        if (adv) begin
          state_next = ST_IDLE;
        end
      end
      ST_PULL: begin
        e_kind = KIND_PULL;
        e_tag  = cur.buffer_tag;
        if (adv) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        e_kind = KIND_DONE;
        e_tag  = cur.buffer_tag;
        e_last = !nxt_valid;
        if (adv) begin
          if (nxt_valid) begin
            ent_next      = nxt;
            port_idx_next = PW_CTRL;
            state_next    = ST_PORT;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PORT: begin
        e_addr = pw_addr;
        e_val  = pw_val;
        e_last = (port_idx == PW_CMD) && ent.is_read;
        if (adv) begin
          if (port_idx == PW_CMD) begin
            state_next = ent.is_read ? ST_IDLE : ST_PUSH;
          end else begin
            port_idx_next = port_idx + 3'd1;
          end
        end
      end
      ST_PUSH: begin
        e_kind = KIND_PUSH;
        e_tag  = ent.buffer_tag;
        e_last = 1'b1;
        if (adv) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
    if (cmd_pop) begin
      cur       <= cmd_data.cur;
      nxt       <= cmd_data.nxt;
      nxt_valid <= cmd_data.nxt_valid;
    end
    if (emit) begin
      result_kind  <= e_kind;
      port_address <= e_addr;
      port_value   <= e_val;
      result_tag   <= e_tag;
      last_result  <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      port_idx  <= PW_CTRL;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      port_idx <= port_idx_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/disk_request_queue_lba28_issuer.sv -----
// Top level of the disk request queue with ATA LBA28 command issue.
// Submit requests wait in a first-in, first-out queue of QUEUE_DEPTH entries; when the drive
// is idle the oldest one is issued as seven ATA register writes (control, sector count, three
// LBA bytes, device select, command), followed by a push-data result for a write. A completion
// interrupt while the drive is busy gives a pull-data result for a read, a done result, and the
// issue of the next queued request. Results leave one per cycle through an output register while
// out_ready is high, and an item that issues a command gives at most ten results; an interrupt
// also passes a fetch state in the front end for the queue memory read of the next request.
// The front end keeps accepting items while earlier results drain, until its two-entry command
// queue is full; a submit to a full request queue is answered by one rejected result, and an
// interrupt while idle gives no result. The queue memory needs no clearing after reset.
`include "disk_request_queue_lba28_issuer_macros.svh"
module disk_request_queue_lba28_issuer import drq_pkg::*; #(
  parameter int QUEUE_DEPTH       = 16,
  parameter int SECTORS_PER_BLOCK = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic        is_read,
  input  logic [26:0] block_number,
  input  logic [7:0]  buffer_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  result_kind,
  output logic [9:0]  port_address,
  output logic [7:0]  port_value,
  output logic [7:0]  result_tag,
  output logic        last_result
);

  cfg_t        cfg;
  cmd_t        cmd_in;
  cmd_t        cmd_out;
  logic        cmd_push;
  logic        cmd_room;
  logic        cmd_avail;
  logic        cmd_pop;
  front_stat_t fstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_select <= 1'b0;
      cfg.read_opcode  <= READ_OPCODE_RESET;
      cfg.write_opcode <= WRITE_OPCODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DRIVE_SELECT: cfg.drive_select <= cfg_data[0];
        REG_READ_OPCODE:  cfg.read_opcode  <= cfg_data;
        REG_WRITE_OPCODE: cfg.write_opcode <= cfg_data;
        default: ;
      endcase
    end
  end

  drq_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .is_read      (is_read),
    .block_number (block_number),
    .buffer_tag   (buffer_tag),
    .cmd_push     (cmd_push),
    .cmd_data     (cmd_in),
    .cmd_room     (cmd_room),
    .stat         (fstat)
  );

  drq_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .room      (cmd_room),
    .pop       (cmd_pop),
    .avail     (cmd_avail),
    .pop_data  (cmd_out)
  );

  drq_back #(
    .SECTORS_PER_BLOCK(SECTORS_PER_BLOCK)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_avail    (cmd_avail),
    .cmd_data     (cmd_out),
    .cmd_pop      (cmd_pop),
    .cfg          (cfg),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .port_address (port_address),
    .port_value   (port_value),
    .result_tag   (result_tag),
    .last_result  (last_result)
  );

  `DRQ_ASSERT(a_busy_has_entry, fstat.busy |-> !fstat.empty, "Drive busy with an empty queue.")
  `DRQ_ASSERT(a_reject_keeps_full, (in_valid && in_ready && (req_type == REQ_SUBMIT) && fstat.full) |=> fstat.full, "Rejected submit changed the queue fill.")
  `DRQ_ASSERT(a_cmd_no_overflow, cmd_push |-> cmd_room, "Command pushed into a full command queue.")
  `DRQ_ASSERT(a_port_write_untagged, (out_valid && (result_kind == KIND_PORT)) |-> (result_tag == 8'h00), "Port write carries a buffer tag.")
  `DRQ_ASSERT_ALWAYS(a_reset_clears_output, rst |=> !out_valid, "Result valid after reset.")

endmodule
